/* rtl/ttu_pkg.sv */
// Shared types and constants of the track table update block.
package ttu_pkg;

	// input item kinds
	localparam logic [1:0] KIND_FRAME_START = 2'd0;
	localparam logic [1:0] KIND_DETECTION   = 2'd1;
	localparam logic [1:0] KIND_FRAME_END   = 2'd2;

	// verdict codes
	localparam logic [1:0] ACT_ADDED   = 2'd0;
	localparam logic [1:0] ACT_UPDATED = 2'd1;
	localparam logic [1:0] ACT_REMOVED = 2'd2;
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	// report kinds
	localparam logic RK_VERDICT = 1'b0;
	localparam logic RK_REPORT  = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_MARGIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LIFE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd4;

	// width of the slot field
	localparam int unsigned SLOT_W = 4;

	// distance that stands for "no match yet"
	localparam logic [13:0] NO_MATCH_DIST = 14'd10000;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [11:0]        w;
		logic [11:0]        h;
		logic [7:0]         life;
	} entry_t;

	// one result beat
	typedef struct packed {
		logic               report_kind;
		logic [1:0]         action;
		logic [SLOT_W-1:0]  slot;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [11:0]        w;
		logic [11:0]        h;
		logic [7:0]         life;
		logic               entry_valid;
		logic               last;
	} result_t;

endpackage

/* rtl/ttu_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ttu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                               rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/track_table_update.sv */
// Track table update: ordered table of tracked boxes with life counts, updated by items.
//
// An item is taken when start is high and busy is low; busy stays high while the
// sequencer walks the table, one entry per cycle through the table RAM's read port.
// Frame start gives no result. A detection gives one verdict beat; a removal adds a
// compaction walk. A frame end makes two walks: one deletes dead entries and applies
// the offset, a second reports the survivors, one beat per cycle, last set on the
// final one. Results appear for one cycle on result_valid and cannot be held off.
// Configuration writes are taken at any time but belong to idle periods.
module track_table_update #(
	parameter int MAX_TARGETS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [11:0]           cfg_data,
	// command
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [11:0]           box_x,
	input  logic [11:0]           box_y,
	input  logic [11:0]           box_w,
	input  logic [11:0]           box_h,
	input  logic                  no_new_targets,
	input  logic signed [15:0]    shift_x,
	input  logic signed [15:0]    shift_y,
	// results
	output logic                  result_valid,
	output logic                  report_kind,
	output logic [1:0]            action,
	output logic [3:0]            slot,
	output logic signed [15:0]    target_x,
	output logic signed [15:0]    target_y,
	output logic [11:0]           target_w,
	output logic [11:0]           target_h,
	output logic [7:0]            life_left,
	output logic                  entry_valid,
	output logic                  last
);
	import ttu_pkg::*;

	localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CNT_W = $clog2(MAX_TARGETS + 1);
	localparam int ENT_W = $bits(entry_t);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TARGETS);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DEC    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_SHIFT  = 3'd4;
	localparam logic [2:0] ST_COMP   = 3'd5;
	localparam logic [2:0] ST_REPORT = 3'd6;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [CNT_W-1:0] v);
		logic [CNT_W+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, v};
		return wide[SLOT_W-1:0];
	endfunction

	// configuration registers
	logic [9:0]  pad_margin_q;
	logic [11:0] near_limit_q;
	logic [7:0]  initial_life_q;
	logic [11:0] window_width_q;
	logic [11:0] window_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_margin_q    <= 10'd10;
			near_limit_q    <= 12'd30;
			initial_life_q  <= 8'd5;
			window_width_q  <= 12'd640;
			window_height_q <= 12'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAD_MARGIN:    pad_margin_q    <= cfg_data[9:0];
				CFG_NEAR_LIMIT:    near_limit_q    <= cfg_data;
				CFG_INITIAL_LIFE:  initial_life_q  <= cfg_data[7:0];
				CFG_WINDOW_WIDTH:  window_width_q  <= cfg_data;
				CFG_WINDOW_HEIGHT: window_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state
	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] keep_q;
	logic             rd_vld_s1;
	logic [CNT_W-1:0] rd_idx_s1;
	logic             matched_q;
	logic [13:0]      best_q;
	logic [CNT_W-1:0] best_idx_q;
	entry_t           best_ent_q;
	logic             result_valid_q;
	result_t          res_q;

	// latched item
	logic [11:0]        bx_q, by_q, bw_q, bh_q;
	logic               no_new_q;
	logic signed [15:0] sx_q, sy_q;

	// table RAM
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [ENT_W-1:0] ram_rdata;
	entry_t           rd_ent;
	logic             issue;
	logic             walk_done;
	logic             in_walk;

	assign rd_ent = entry_t'(ram_rdata);

	ttu_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_TARGETS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(iss_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// walk control: one read issued per cycle until the table end
	assign in_walk = (state_q == ST_DEC) || (state_q == ST_SCAN) || (state_q == ST_SHIFT) ||
		(state_q == ST_COMP) || (state_q == ST_REPORT);
	assign issue     = in_walk && (iss_q < count_q);
	assign walk_done = in_walk && (iss_q == count_q) && !rd_vld_s1;

	// padded window test
	logic signed [13:0] right_x, right_y, lim_x, lim_y;
	logic               in_window;

	assign right_x = signed'({2'b00, bx_q}) + signed'({2'b00, bw_q});
	assign right_y = signed'({2'b00, by_q}) + signed'({2'b00, bh_q});
	assign lim_x   = signed'({2'b00, window_width_q}) - signed'({4'b0000, pad_margin_q});
	assign lim_y   = signed'({2'b00, window_height_q}) - signed'({4'b0000, pad_margin_q});
	assign in_window = ({2'b00, bx_q} > {4'b0000, pad_margin_q}) &&
		({2'b00, by_q} > {4'b0000, pad_margin_q}) &&
		(right_x < lim_x) && (right_y < lim_y);

	// shared distance unit
	logic signed [17:0] diff_x, diff_y;
	logic [17:0]        abs_x, abs_y;
	logic               near_ok;
	logic [12:0]        gap_sum;

	assign diff_x  = signed'({6'd0, bx_q}) - signed'({{2{rd_ent.x[15]}}, rd_ent.x});
	assign diff_y  = signed'({6'd0, by_q}) - signed'({{2{rd_ent.y[15]}}, rd_ent.y});
	assign abs_x   = diff_x[17] ? 18'(-diff_x) : 18'(diff_x);
	assign abs_y   = diff_y[17] ? 18'(-diff_y) : 18'(diff_y);
	assign near_ok = (abs_x <= {6'd0, near_limit_q}) && (abs_y <= {6'd0, near_limit_q});
	assign gap_sum = {1'b0, abs_x[11:0]} + {1'b0, abs_y[11:0]};

	// offset with saturation
	logic signed [16:0] sum_x, sum_y;
	logic signed [15:0] moved_x, moved_y;

	assign sum_x = {rd_ent.x[15], rd_ent.x} + {sx_q[15], sx_q};
	assign sum_y = {rd_ent.y[15], rd_ent.y} + {sy_q[15], sy_q};
	assign moved_x = (sum_x[16] != sum_x[15]) ? (sum_x[16] ? 16'sh8000 : 16'sh7fff) :
		sum_x[15:0];
	assign moved_y = (sum_y[16] != sum_y[15]) ? (sum_y[16] ? 16'sh8000 : 16'sh7fff) :
		sum_y[15:0];

	// entry life after update
	logic [7:0] life_up;
	assign life_up = (best_ent_q.life == 8'hff) ? 8'hff : best_ent_q.life + 8'd1;

	// new entry from the detected box
	entry_t box_ent;
	assign box_ent = '{x: signed'({4'd0, bx_q}), y: signed'({4'd0, by_q}),
		w: bw_q, h: bh_q, life: initial_life_q};

	logic [CNT_W-1:0] prev_idx;
	logic [CNT_W-1:0] keep_prev;
	logic             can_add;
	assign prev_idx  = rd_idx_s1 - 1'b1;
	assign keep_prev = count_q - 1'b1;
	assign can_add   = !no_new_q && in_window && (count_q < MAX_CNT);

	// RAM write selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = keep_q[IDX_W-1:0];
		ram_wdata = rd_ent;
		unique case (state_q)
			ST_DEC: begin
				ram_we    = rd_vld_s1;
				ram_waddr = rd_idx_s1[IDX_W-1:0];
				ram_wdata.life = (rd_ent.life != 8'd0) ? rd_ent.life - 8'd1 : 8'd0;
			end
			ST_COMP: begin
				ram_we    = rd_vld_s1 && (rd_ent.life != 8'd0);
				ram_waddr = keep_q[IDX_W-1:0];
				ram_wdata.x = moved_x;
				ram_wdata.y = moved_y;
			end
			ST_SHIFT: begin
				ram_we    = rd_vld_s1;
				ram_waddr = prev_idx[IDX_W-1:0];
			end
			ST_DECIDE: begin
				if (!matched_q) begin
					ram_we    = can_add;
					ram_waddr = count_q[IDX_W-1:0];
					ram_wdata = box_ent;
				end else if (in_window) begin
					ram_we    = 1'b1;
					ram_waddr = best_idx_q[IDX_W-1:0];
					ram_wdata = box_ent;
					ram_wdata.life = life_up;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			iss_q          <= '0;
			keep_q         <= '0;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= '0;
			matched_q      <= 1'b0;
			best_q         <= NO_MATCH_DIST;
			best_idx_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			rd_vld_s1      <= issue;
			rd_idx_s1      <= iss_q;
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					iss_q     <= '0;
					keep_q    <= '0;
					matched_q <= 1'b0;
					best_q    <= NO_MATCH_DIST;
					if (start) begin
						case (kind)
							KIND_FRAME_START: state_q <= ST_DEC;
							KIND_DETECTION:   state_q <= ST_SCAN;
							KIND_FRAME_END:   state_q <= ST_COMP;
							default:          state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DEC: begin
					if (walk_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1 && near_ok) begin
						matched_q <= 1'b1;
						if ({1'b0, gap_sum} < best_q) begin
							best_q     <= {1'b0, gap_sum};
							best_idx_q <= rd_idx_s1;
						end
					end
					if (walk_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					result_valid_q <= 1'b1;
					if (!matched_q) begin
						state_q <= ST_IDLE;
						if (can_add) begin
							count_q <= count_q + 1'b1;
						end
					end else if (in_window) begin
						state_q <= ST_IDLE;
					end else begin
						iss_q   <= best_idx_q + 1'b1;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (walk_done) begin
						count_q <= keep_prev;
						state_q <= ST_IDLE;
					end
				end
				ST_COMP: begin
					if (rd_vld_s1 && (rd_ent.life != 8'd0)) begin
						keep_q <= keep_q + 1'b1;
					end
					if (walk_done) begin
						count_q <= keep_q;
						iss_q   <= '0;
						if (keep_q == '0) begin
							result_valid_q <= 1'b1;
							state_q        <= ST_IDLE;
						end else begin
							state_q <= ST_REPORT;
						end
					end
				end
				ST_REPORT: begin
					result_valid_q <= rd_vld_s1;
					if (walk_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// best entry payload captured during the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && rd_vld_s1 && near_ok && ({1'b0, gap_sum} < best_q)) begin
			best_ent_q <= rd_ent;
		end
	end

	// latch the item on accept
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			bx_q     <= box_x;
			by_q     <= box_y;
			bw_q     <= box_w;
			bh_q     <= box_h;
			no_new_q <= no_new_targets;
			sx_q     <= shift_x;
			sy_q     <= shift_y;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DECIDE: begin
				res_q.report_kind <= RK_VERDICT;
				res_q.last        <= 1'b1;
				res_q.entry_valid <= 1'b1;
				res_q.x           <= box_ent.x;
				res_q.y           <= box_ent.y;
				res_q.w           <= bw_q;
				res_q.h           <= bh_q;
				if (!matched_q) begin
					if (can_add) begin
						res_q.action <= ACT_ADDED;
						res_q.slot   <= to_slot(count_q);
						res_q.life   <= initial_life_q;
					end else begin
						res_q.action      <= ACT_IGNORED;
						res_q.slot        <= '0;
						res_q.life        <= '0;
						res_q.entry_valid <= 1'b0;
					end
				end else if (in_window) begin
					res_q.action <= ACT_UPDATED;
					res_q.slot   <= to_slot(best_idx_q);
					res_q.life   <= life_up;
				end else begin
					res_q.action <= ACT_REMOVED;
					res_q.slot   <= to_slot(best_idx_q);
					res_q.x      <= best_ent_q.x;
					res_q.y      <= best_ent_q.y;
					res_q.w      <= best_ent_q.w;
					res_q.h      <= best_ent_q.h;
					res_q.life   <= best_ent_q.life;
				end
			end
			ST_COMP: begin
				// empty table report
				res_q <= '{report_kind: RK_REPORT, action: ACT_ADDED, slot: '0,
					x: '0, y: '0, w: '0, h: '0, life: '0, entry_valid: 1'b0, last: 1'b1};
			end
			ST_REPORT: begin
				res_q.report_kind <= RK_REPORT;
				res_q.action      <= ACT_ADDED;
				res_q.slot        <= to_slot(rd_idx_s1);
				res_q.x           <= rd_ent.x;
				res_q.y           <= rd_ent.y;
				res_q.w           <= rd_ent.w;
				res_q.h           <= rd_ent.h;
				res_q.life        <= rd_ent.life;
				res_q.entry_valid <= 1'b1;
				res_q.last        <= (rd_idx_s1 == keep_prev);
			end
			default: ;
		endcase
	end

	// outputs
	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign report_kind  = res_q.report_kind;
	assign action       = res_q.action;
	assign slot         = res_q.slot;
	assign target_x     = res_q.x;
	assign target_y     = res_q.y;
	assign target_w     = res_q.w;
	assign target_h     = res_q.h;
	assign life_left    = res_q.life;
	assign entry_valid  = res_q.entry_valid;
	assign last         = res_q.last;

endmodule
